[design/ewma_eid_pkg.sv]
package ewma_eid_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int ACC_W       = 16;
	localparam int PAD_W       = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_ADDR_W  = 1;
	localparam int RES_BITS    = 3 + 2 * ACC_W;
	localparam int M_TDATA_W   = ((RES_BITS + 7) / 8) * 8;

	localparam logic [CFG_ADDR_W-1:0] REG_NOISE_PADDING = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_HOLD_SAMPLES  = 1'd1;

	localparam logic [PAD_W-1:0] NOISE_PADDING_RST = 8'd16;
	localparam logic [ACC_W-1:0] HOLD_SAMPLES_RST  = 16'd200;
	localparam logic [ACC_W-1:0] BIAS_RST          = 16'd511;
	localparam logic [ACC_W-1:0] HIGH_RST          = 16'd520;
	localparam logic [ACC_W-1:0] LOW_RST           = 16'd500;
	localparam logic [ACC_W:0]   EWMA_OFFSET       = 17'd8;

	typedef struct packed {
		logic [ACC_W-1:0] bias;
		logic [ACC_W-1:0] high;
		logic [ACC_W-1:0] low;
		logic [ACC_W-1:0] hold;
		logic             sw;
	} det_state_t;

	typedef struct packed {
		logic [ACC_W-1:0] high_envelope;
		logic [ACC_W-1:0] low_envelope;
		logic             switch_on;
		logic             above_pulse;
		logic             below_pulse;
	} det_result_t;

	// m + x - floor((m - 8) / 16), wrapped to the accumulator width
	function automatic logic [ACC_W-1:0] ewma_upd(input logic [SAMPLE_BITS-1:0] x,
			input logic [ACC_W-1:0] m);
		logic signed [ACC_W:0] d;
		logic [ACC_W:0]        s;
		d = $signed({1'b0, m}) - $signed(EWMA_OFFSET);
		d = d >>> 4;
		s = {1'b0, m} + (ACC_W + 1)'(x) - $unsigned(d);
		return s[ACC_W-1:0];
	endfunction

endpackage

[design/ewma_envelope_impulse_detector.sv]
// Path: an accepted sample is registered in sample_s1, and its result is then registered in
// res_q and presented on m_tdata; a stall on the output side can hold it in between.
// Throughput: one sample per cycle while the output side is not stalled; the update loop of
// the three averages and the hold timer is combinational and sets that figure.
// Reset: arst_n clears both valid flags, loads the averages with 511/520/500, the hold
// timer with 0, the switch off, noise_padding with 16 and hold_samples with 200.
module ewma_envelope_impulse_detector import ewma_eid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// below_pulse, above_pulse, switch_on, low_envelope, high_envelope
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [PAD_W-1:0]       noise_padding_q;
	logic [ACC_W-1:0]       hold_samples_q;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   out_valid_q;
	det_result_t            res_q;
	det_state_t             state_q;
	det_state_t             state_n;
	det_result_t            res_n;
	logic                   advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_padding_q <= NOISE_PADDING_RST;
			hold_samples_q  <= HOLD_SAMPLES_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_NOISE_PADDING: noise_padding_q <= cfg_wdata[PAD_W-1:0];
				REG_HOLD_SAMPLES:  hold_samples_q  <= cfg_wdata[ACC_W-1:0];
				default:           ;
			endcase
		end
	end

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
		end
	end

	ewma_eid_step u_step (
		.x             (sample_s1),
		.cur           (state_q),
		.noise_padding (noise_padding_q),
		.hold_samples  (hold_samples_q),
		.nxt           (state_n),
		.res           (res_n)
	);

	// commit state only when the transaction moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.bias <= BIAS_RST;
			state_q.high <= HIGH_RST;
			state_q.low  <= LOW_RST;
			state_q.hold <= '0;
			state_q.sw   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({res_q.high_envelope, res_q.low_envelope,
		res_q.switch_on, res_q.above_pulse, res_q.below_pulse});

	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.below_pulse && res_q.above_pulse))
		else $error("both pulse flags set");

	a_pulse_switch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.below_pulse || res_q.above_pulse) |-> res_q.switch_on)
		else $error("detection without switch on");

	a_hold_implies_on: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hold != '0 |-> state_q.sw)
		else $error("hold timer running with switch off");

	a_state_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(state_q))
		else $error("state changed without a transaction");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance && valid_s1 |=> out_valid_q)
		else $error("result lost on advance");

endmodule

[design/ewma_eid_step.sv]
module ewma_eid_step import ewma_eid_pkg::*; (
	input  logic [SAMPLE_BITS-1:0] x,
	input  det_state_t             cur,
	input  logic [PAD_W-1:0]       noise_padding,
	input  logic [ACC_W-1:0]       hold_samples,
	output det_state_t             nxt,
	output det_result_t            res
);

	logic [ACC_W-1:0]        bias_n;
	logic [ACC_W-5:0]        centre;
	logic [ACC_W-1:0]        noise;
	logic signed [ACC_W+1:0] diff;
	logic signed [ACC_W+1:0] lower;
	logic [ACC_W+1:0]        upper;
	logic signed [ACC_W+1:0] sx;
	logic                    below;
	logic                    above;

	always_comb begin
		bias_n   = ewma_upd(x, cur.bias);
		centre   = bias_n[ACC_W-1:4];
		nxt      = cur;
		nxt.bias = bias_n;
		if ((ACC_W - 4)'(x) > centre) begin
			nxt.high = ewma_upd(x, cur.high);
		end
		if ((ACC_W - 4)'(x) < centre) begin
			nxt.low = ewma_upd(x, cur.low);
		end

		noise = nxt.high - nxt.low + ACC_W'(noise_padding);

		// lower threshold can go negative, floor toward minus infinity
		diff  = $signed({2'b00, bias_n}) - $signed({2'b00, noise});
		lower = diff >>> 4;
		upper = ({2'b00, bias_n} + {2'b00, noise}) >> 4;
		sx    = $signed((ACC_W + 2)'(x));

		below = sx < lower;
		above = !below && ((ACC_W + 2)'(x) > upper);

		if (below || above) begin
			nxt.sw   = 1'b1;
			nxt.hold = hold_samples;
		end else if (cur.hold != '0) begin
			nxt.hold = cur.hold - ACC_W'(1);
		end else begin
			nxt.sw = 1'b0;
		end

		res.below_pulse   = below;
		res.above_pulse   = above;
		res.switch_on     = nxt.sw;
		res.low_envelope  = nxt.low;
		res.high_envelope = nxt.high;
	end

endmodule

[verif/tb_ewma_envelope_impulse_detector.sv]
`timescale 1ns / 1ps

import ewma_eid_pkg::*;

class envelope_scoreboard;
	logic [PAD_W-1:0] noise_padding;
	logic [ACC_W-1:0] hold_samples;
	logic [ACC_W-1:0] bias_avg;
	logic [ACC_W-1:0] high_avg;
	logic [ACC_W-1:0] low_avg;
	logic [ACC_W-1:0] hold_count;
	logic             switch_state;
	det_result_t      expected_q[$];
	int               mismatches;
	int               results_seen;

	function new();
		noise_padding = NOISE_PADDING_RST;
		hold_samples  = HOLD_SAMPLES_RST;
		bias_avg      = BIAS_RST;
		high_avg      = HIGH_RST;
		low_avg       = LOW_RST;
		hold_count    = '0;
		switch_state  = 1'b0;
		mismatches    = 0;
		results_seen  = 0;
	endfunction

	function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_NOISE_PADDING: noise_padding = val[PAD_W-1:0];
			REG_HOLD_SAMPLES:  hold_samples = val[ACC_W-1:0];
			default: ;
		endcase
	endfunction

	// x + m - floor((m - 8) / 16), wrapped to 16 bits
	function logic [ACC_W-1:0] smooth(logic [SAMPLE_BITS-1:0] x, logic [ACC_W-1:0] m);
		int decay;
		int sum;
		decay = (int'(m) - 8) >>> 4;
		sum = int'(x) + int'(m) - decay;
		return sum[ACC_W-1:0];
	endfunction

	function void note_sample(logic [SAMPLE_BITS-1:0] x);
		det_result_t      r;
		logic [ACC_W-1:0] centre;
		logic [ACC_W-1:0] noise;
		int               lower;
		int               upper;
		bias_avg = smooth(x, bias_avg);
		centre = bias_avg >> 4;
		if (ACC_W'(x) > centre)
			high_avg = smooth(x, high_avg);
		if (ACC_W'(x) < centre)
			low_avg = smooth(x, low_avg);
		noise = high_avg - low_avg + ACC_W'(noise_padding);
		// thresholds are signed; the arithmetic shift floors toward minus infinity
		lower = (int'(bias_avg) - int'(noise)) >>> 4;
		upper = (int'(bias_avg) + int'(noise)) >>> 4;
		r = '0;
		if (int'(x) < lower)
			r.below_pulse = 1'b1;
		else if (int'(x) > upper)
			r.above_pulse = 1'b1;
		if (r.below_pulse || r.above_pulse) begin
			switch_state = 1'b1;
			hold_count = hold_samples;
		end else if (hold_count != 0) begin
			hold_count = hold_count - ACC_W'(1);
		end else begin
			switch_state = 1'b0;
		end
		r.switch_on = switch_state;
		r.low_envelope = low_avg;
		r.high_envelope = high_avg;
		expected_q.push_back(r);
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	task report(string what);
		if (mismatches < 100)
			$display("ERROR: %s", what);
		mismatches++;
	endtask

	task check_result(det_result_t got);
		det_result_t want;
		results_seen++;
		if (expected_q.size() == 0) begin
			report($sformatf("result %0d arrived with nothing expected", results_seen));
			return;
		end
		want = expected_q.pop_front();
		if (got.below_pulse !== want.below_pulse)
			report($sformatf("result %0d below_pulse %0b, expected %0b", results_seen,
				got.below_pulse, want.below_pulse));
		if (got.above_pulse !== want.above_pulse)
			report($sformatf("result %0d above_pulse %0b, expected %0b", results_seen,
				got.above_pulse, want.above_pulse));
		if (got.switch_on !== want.switch_on)
			report($sformatf("result %0d switch_on %0b, expected %0b", results_seen,
				got.switch_on, want.switch_on));
		if (got.low_envelope !== want.low_envelope)
			report($sformatf("result %0d low_envelope %h, expected %h", results_seen,
				got.low_envelope, want.low_envelope));
		if (got.high_envelope !== want.high_envelope)
			report($sformatf("result %0d high_envelope %h, expected %h", results_seen,
				got.high_envelope, want.high_envelope));
	endtask
endclass

module tb_ewma_envelope_impulse_detector;
	import ewma_eid_pkg::*;

	localparam int MAX_SAMPLE   = (1 << SAMPLE_BITS) - 1;
	localparam int PHASES       = 8;
	localparam int RAND_ITEMS   = 120;
	localparam int HOLDOFF_AT   = 400;
	localparam int HOLDOFF_LEN  = 100;
	localparam int STALL_LIMIT  = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // sample
	logic                  m_tvalid;
	logic                  m_tready;
	// below_pulse, above_pulse, switch_on, low_envelope, high_envelope
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	envelope_scoreboard sb = new();

	int level = 512;
	int jitter = 4;
	int tx_burst = 0;
	int rx_burst = 0;
	int stall_cycles = 0;

	ewma_envelope_impulse_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly a jittery baseline that now and then jumps to a new level, with
	// impulses and full-range noise mixed in.
	function automatic logic [SAMPLE_BITS-1:0] next_sample();
		int pick;
		int v;
		pick = $urandom_range(0, 199);
		if (pick < 3) begin
			case ($urandom_range(0, 3))
				0: level = 0;
				1: level = MAX_SAMPLE;
				default: level = $urandom_range(0, MAX_SAMPLE);
			endcase
			jitter = $urandom_range(0, 12);
			v = level;
		end else if (pick < 13) begin
			if ($urandom_range(0, 1))
				v = MAX_SAMPLE - $urandom_range(0, 40);
			else
				v = $urandom_range(0, 40);
		end else if (pick < 21) begin
			v = $urandom_range(0, MAX_SAMPLE);
		end else begin
			v = level + $urandom_range(0, 2 * jitter) - jitter;
			if (v < 0)
				v = 0;
			if (v > MAX_SAMPLE)
				v = MAX_SAMPLE;
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// Entered and left at a falling edge; valid stays high between back-to-back items.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] x);
		int gap;
		if (tx_burst > 0) begin
			tx_burst--;
			gap = 0;
		end else if ($urandom_range(0, 15) == 0) begin
			tx_burst = $urandom_range(10, 40);
			gap = 0;
		end else begin
			gap = $urandom_range(0, 8);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - SAMPLE_BITS){1'b0}}, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(x);
		@(negedge clk);
	endtask

	initial begin
		logic [SAMPLE_BITS-1:0] directed [25];
		logic [PAD_W-1:0]       pad;
		logic [ACC_W-1:0]       hold;
		directed = '{10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd511, 10'd512, 10'd480,
			10'd0, 10'd0, 10'd1023, 10'd1023, 10'd300, 10'd31, 10'd32, 10'd33, 10'd32,
			10'd32, 10'd32, 10'd32, 10'd32, 10'd32, 10'd32, 10'd32, 10'd1, 10'd1022};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin pad = 8'd16;  hold = 16'd5;     end
				1: begin pad = 8'd0;   hold = 16'd0;     end
				2: begin pad = 8'd255; hold = 16'd65535; end
				3: begin pad = 8'd16;  hold = 16'd200;   end
				4: begin
					pad = PAD_W'($urandom_range(0, 255));
					hold = ACC_W'($urandom_range(0, 20));
				end
				5: begin pad = 8'd255; hold = 16'd0;     end
				6: begin pad = 8'd0;   hold = 16'd65535; end
				default: begin
					pad = PAD_W'($urandom_range(0, 255));
					hold = ACC_W'($urandom_range(0, 65535));
				end
			endcase
			write_reg(REG_NOISE_PADDING, CFG_DATA_W'(pad));
			write_reg(REG_HOLD_SAMPLES, CFG_DATA_W'(hold));
			cfg_we <= 1'b0;
			if (p == 0) begin
				foreach (directed[i])
					send_sample(directed[i]);
			end
			repeat (RAND_ITEMS)
				send_sample(next_sample());
			s_tvalid <= 1'b0;
			// drain before touching the registers again
			while (sb.pending() != 0)
				@(negedge clk);
			repeat (4) @(negedge clk);
		end
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_ewma_envelope_impulse_detector passed");
		else
			$display("tb_ewma_envelope_impulse_detector failed");
		$finish;
	end

	// Output side: random back-pressure, plus one long hold-off to fill the block.
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (sb.results_seen == HOLDOFF_AT) begin
				gap = HOLDOFF_LEN;
			end else if (rx_burst > 0) begin
				rx_burst--;
				gap = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				rx_burst = $urandom_range(10, 40);
				gap = 0;
			end else begin
				gap = $urandom_range(0, 8);
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			sb.check_result(det_result_t'(m_tdata[RES_BITS-1:0]));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("tb_ewma_envelope_impulse_detector failed");
				$finish;
			end
		end
	end

endmodule

[files.f]
design/ewma_eid_pkg.sv
design/ewma_eid_step.sv
design/ewma_envelope_impulse_detector.sv
verif/tb_ewma_envelope_impulse_detector.sv
